@@ rtl/core/lps_pkg.sv @@
// Shared types, widths and codes for the line pixel stepper.
`timescale 1ns / 1ps

package lps_pkg;

  localparam int FRAC_BITS_DEF = 4;
  localparam int OFFSET_BITS   = 24;

  localparam int COORD_W    = 16;
  localparam int DELTA_W    = COORD_W + 1;
  localparam int MAG_W      = 16;
  localparam int STEP_W     = 13;
  localparam int DIM_W      = 12;
  localparam int STRIDE_W   = 16;
  localparam int PBITS_W    = 6;
  localparam int BPP_W      = PBITS_W - 3;
  localparam int COLOR_W    = 32;
  localparam int OFF_W      = 24;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam int PROD_W = 2 * MAG_W;
  localparam int RAD_W  = 34;
  localparam int ROOT_W = RAD_W / 2;
  localparam int QUO_W  = MAG_W;
  localparam int REM_W  = 20;
  localparam int CNT_W  = $clog2(ROOT_W + 1);
  localparam int V_W    = 19;
  localparam int SUM_W  = 32;

  localparam logic [STEP_W-1:0]   STEP_MAX   = '1;
  localparam logic [DIM_W-1:0]    WIDTH_RST  = 12'd640;
  localparam logic [DIM_W-1:0]    HEIGHT_RST = 12'd480;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 16'd2560;
  localparam logic [PBITS_W-1:0]  PBITS_RST  = 6'd32;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_ROW_STRIDE   = 2'd2,
    CFG_PIXEL_BITS   = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    ITER_SQRT = 1'b0,
    ITER_DIV  = 1'b1
  } iter_mode_t;

  typedef struct packed {
    action_t                    action;
    logic signed [COORD_W-1:0]  x_start;
    logic signed [COORD_W-1:0]  y_start;
    logic signed [COORD_W-1:0]  x_end;
    logic signed [COORD_W-1:0]  y_end;
    logic [COLOR_W-1:0]         draw_color;
  } in_t;

  typedef struct packed {
    logic [OFF_W-1:0]   pixel_offset;
    logic [COLOR_W-1:0] pixel_color;
    logic               pixel_in_bounds;
    logic               line_done;
  } out_t;

  typedef struct packed {
    logic load_line;
    logic sqr_mul;
    logic sqrt_start;
    logic set_total;
    logic step_mul;
    logic div_start;
    logic pix_calc;
    logic off_mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic iter_done;
    logic step_avail;
  } stat_t;

endpackage

@@ rtl/core/line_pixel_stepper_core.sv @@
// Top level of the line pixel stepper: sequencer plus datapath.
// Load: the next beat waits until the 17-step root unit has produced the line length.
// Step: two 16-step divide lanes run in parallel, then the pixel reaches the output register,
// held back while a stalled output beat is still there; the next beat is taken once it is
// loaded. Synchronous active-low reset restores 640 x 480, stride 2560, 32 bits per pixel,
// and clears the step count and index.
`timescale 1ns / 1ps

module line_pixel_stepper_core #(
  parameter int FRAC_BITS = lps_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lps_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lps_pkg::out_t                     out_data
);
  import lps_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lps_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("output register loaded while a stalled beat is held");

  a_empty_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.action == ACT_STEP) && !stat.step_avail)
      |=> !in_stall)
    else $error("step with no pixels left did not return to idle");

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat.iter_done |-> in_stall)
    else $error("root or divide result arrived while the sequencer was idle");

endmodule

@@ rtl/core/lps_iter.sv @@
// Shift-subtract unit: integer square root or division, one result bit per cycle.
`timescale 1ns / 1ps

module lps_iter (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  lps_pkg::iter_mode_t            mode,
  input  logic [lps_pkg::RAD_W-1:0]      operand,
  input  logic [lps_pkg::STEP_W-1:0]     divisor,
  output logic                           done,
  output logic [lps_pkg::ROOT_W-1:0]     result
);
  import lps_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  iter_mode_t         mode_r, mode_nxt;
  logic [RAD_W-1:0]   opnd_r, opnd_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [ROOT_W-1:0]  res_r, res_nxt;
  logic [REM_W-1:0]   shifted;
  logic [REM_W-1:0]   trial;
  logic               fits;

  // Square root brings in two radicand bits per step, division one dividend bit.
  always_comb begin
    if (mode_r == ITER_SQRT) begin
      shifted = {rem_r[REM_W-3:0], opnd_r[RAD_W-1 -: 2]};
      trial   = REM_W'({res_r, 2'b01});
    end else begin
      shifted = {rem_r[REM_W-2:0], opnd_r[RAD_W-1]};
      trial   = REM_W'(divisor);
    end
    fits = (shifted >= trial);
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    opnd_nxt = opnd_r;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    if (start) begin
      busy_nxt = 1'b1;
      mode_nxt = mode;
      res_nxt  = '0;
      if (mode == ITER_SQRT) begin
        cnt_nxt  = CNT_W'(ROOT_W);
        opnd_nxt = operand;
        rem_nxt  = '0;
      end else begin
        // The quotient is known to fit in QUO_W bits, so the upper dividend
        // bits already form a partial remainder below the divisor.
        cnt_nxt  = CNT_W'(QUO_W);
        opnd_nxt = {operand[QUO_W-1:0], {(RAD_W-QUO_W){1'b0}}};
        rem_nxt  = REM_W'(operand[RAD_W-1:QUO_W]);
      end
    end else if (busy_r) begin
      cnt_nxt  = cnt_r - CNT_W'(1);
      rem_nxt  = fits ? (shifted - trial) : shifted;
      res_nxt  = {res_r[ROOT_W-2:0], fits};
      opnd_nxt = (mode_r == ITER_SQRT) ? (opnd_r << 2) : (opnd_r << 1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      mode_r <= ITER_SQRT;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opnd_r <= opnd_nxt;
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

@@ rtl/core/lps_ctrl.sv @@
// Sequencer that steps the datapath through a line load or one pixel step.
`timescale 1ns / 1ps

module lps_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  lps_pkg::action_t in_action,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  lps_pkg::stat_t   stat,
  output lps_pkg::cmd_t    cmd
);
  import lps_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_LD_SQR  = 9'b000000010,
    S_LD_ROOT = 9'b000000100,
    S_LD_WAIT = 9'b000001000,
    S_ST_MUL  = 9'b000010000,
    S_ST_DIV  = 9'b000100000,
    S_ST_WAIT = 9'b001000000,
    S_ST_OFF  = 9'b010000000,
    S_ST_OUT  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_action == ACT_LOAD) begin
            cmd.load_line = 1'b1;
            state_nxt     = S_LD_SQR;
          end else if (stat.step_avail) begin
            state_nxt = S_ST_MUL;
          end
        end
      end
      S_LD_SQR: begin
        cmd.sqr_mul = 1'b1;
        state_nxt   = S_LD_ROOT;
      end
      S_LD_ROOT: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_LD_WAIT;
      end
      S_LD_WAIT: begin
        if (stat.iter_done) begin
          cmd.set_total = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ST_MUL: begin
        cmd.step_mul = 1'b1;
        state_nxt    = S_ST_DIV;
      end
      S_ST_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_ST_WAIT;
      end
      S_ST_WAIT: begin
        if (stat.iter_done) begin
          cmd.pix_calc = 1'b1;
          state_nxt    = S_ST_OFF;
        end
      end
      S_ST_OFF: begin
        cmd.off_mul = 1'b1;
        state_nxt   = S_ST_OUT;
      end
      S_ST_OUT: begin
        // The output register may be refilled in the cycle its beat leaves.
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/lps_datapath.sv @@
// Line state, multipliers, root/divide lanes and the pixel offset path.
`timescale 1ns / 1ps

module lps_datapath #(
  parameter int FRAC_BITS = lps_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  lps_pkg::in_t                      in_data,
  input  lps_pkg::cmd_t                     cmd,
  output lps_pkg::stat_t                    stat,
  output lps_pkg::out_t                     out_data
);
  import lps_pkg::*;

  localparam int PIX_W = V_W - FRAC_BITS;
  localparam int HALF  = (1 << FRAC_BITS) >> 1;
  localparam int FMASK = (1 << FRAC_BITS) - 1;
  localparam int CMP_W = 32;
  localparam logic [SUM_W-1:0] OFF_MASK = SUM_W'((64'd1 << OFFSET_BITS) - 64'd1);

  // Origin plus the signed step fraction, rounded by one half and truncated
  // toward zero to whole pixels.
  function automatic logic signed [PIX_W-1:0] to_pixel(
    input logic signed [COORD_W-1:0] org,
    input logic                      neg,
    input logic [QUO_W-1:0]          quo
  );
    logic signed [V_W-1:0] part;
    logic signed [V_W-1:0] v;
    logic signed [V_W-1:0] adj;
    part = V_W'({1'b0, quo});
    if (neg) begin
      part = -part;
    end
    v   = V_W'(org) + part + V_W'(HALF);
    adj = v + (v[V_W-1] ? V_W'(FMASK) : '0);
    return PIX_W'(adj >>> FRAC_BITS);
  endfunction

  logic [DIM_W-1:0]            width_r, height_r;
  logic [STRIDE_W-1:0]         stride_r;
  logic [PBITS_W-1:0]          pbits_r;

  logic signed [COORD_W-1:0]   origin_x_r, origin_y_r;
  logic                        neg_x_r, neg_y_r;
  logic [MAG_W-1:0]            mag_x_r, mag_y_r;
  logic [STEP_W-1:0]           total_r, index_r;
  logic [COLOR_W-1:0]          color_r;
  logic [PROD_W-1:0]           prod_x_r, prod_y_r;
  logic signed [PIX_W-1:0]     px_r, py_r;
  logic                        inb_r;
  logic [DIM_W+STRIDE_W-1:0]   row_prod_r;
  logic [DIM_W+BPP_W-1:0]      col_prod_r;
  out_t                        out_data_r;

  logic signed [DELTA_W-1:0]   dx, dy;
  logic [MAG_W-1:0]            mul_b_x, mul_b_y;
  logic [PROD_W-1:0]           mul_x, mul_y;
  logic                        iter_start_x;
  iter_mode_t                  mode_x;
  logic [RAD_W-1:0]            opnd_x, opnd_y;
  logic                        done_x, done_y;
  logic [ROOT_W-1:0]           res_x, res_y;
  logic [ROOT_W-1:0]           len;
  logic [STEP_W-1:0]           total_nxt;
  logic                        inb_x, inb_y;
  logic [DIM_W-1:0]            px_u, py_u;
  logic [SUM_W-1:0]            off_sum;
  logic [STEP_W-1:0]           index_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      stride_r <= STRIDE_RST;
      pbits_r  <= PBITS_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        CFG_FRAME_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        CFG_ROW_STRIDE:   stride_r <= cfg_wdata[STRIDE_W-1:0];
        CFG_PIXEL_BITS:   pbits_r  <= cfg_wdata[PBITS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign dx = DELTA_W'(in_data.x_end) - DELTA_W'(in_data.x_start);
  assign dy = DELTA_W'(in_data.y_end) - DELTA_W'(in_data.y_start);

  // One multiplier per axis: squares on a load, magnitude times index on a step.
  assign mul_b_x = cmd.sqr_mul ? mag_x_r : MAG_W'(index_r);
  assign mul_b_y = cmd.sqr_mul ? mag_y_r : MAG_W'(index_r);
  assign mul_x   = mag_x_r * mul_b_x;
  assign mul_y   = mag_y_r * mul_b_y;

  assign iter_start_x = cmd.sqrt_start || cmd.div_start;
  assign mode_x       = cmd.sqrt_start ? ITER_SQRT : ITER_DIV;
  assign opnd_x       = cmd.sqrt_start ? (RAD_W'(prod_x_r) + RAD_W'(prod_y_r))
                                       : RAD_W'(prod_x_r);
  assign opnd_y       = RAD_W'(prod_y_r);

  lps_iter u_iter_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (iter_start_x),
    .mode    (mode_x),
    .operand (opnd_x),
    .divisor (total_r),
    .done    (done_x),
    .result  (res_x)
  );

  lps_iter u_iter_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .mode    (ITER_DIV),
    .operand (opnd_y),
    .divisor (total_r),
    .done    (done_y),
    .result  (res_y)
  );

  assign len       = res_x >> FRAC_BITS;
  assign total_nxt = (len > ROOT_W'(STEP_MAX)) ? STEP_MAX : len[STEP_W-1:0];
  assign index_nxt = index_r + STEP_W'(1);

  assign inb_x = !px_r[PIX_W-1] && (CMP_W'($unsigned(px_r)) < CMP_W'(width_r));
  assign inb_y = !py_r[PIX_W-1] && (CMP_W'($unsigned(py_r)) < CMP_W'(height_r));
  assign px_u  = DIM_W'($unsigned(px_r));
  assign py_u  = DIM_W'($unsigned(py_r));

  assign off_sum = (SUM_W'(row_prod_r) + SUM_W'(col_prod_r)) & OFF_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      index_r <= '0;
    end else if (cmd.set_total) begin
      total_r <= total_nxt;
      index_r <= '0;
    end else if (cmd.out_load) begin
      index_r <= index_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_line) begin
      origin_x_r <= in_data.x_start;
      origin_y_r <= in_data.y_start;
      neg_x_r    <= dx[DELTA_W-1];
      neg_y_r    <= dy[DELTA_W-1];
      mag_x_r    <= dx[DELTA_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
      mag_y_r    <= dy[DELTA_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
      color_r    <= in_data.draw_color;
    end
    if (cmd.sqr_mul || cmd.step_mul) begin
      prod_x_r <= mul_x;
      prod_y_r <= mul_y;
    end
    if (cmd.pix_calc) begin
      px_r <= to_pixel(origin_x_r, neg_x_r, res_x[QUO_W-1:0]);
      py_r <= to_pixel(origin_y_r, neg_y_r, res_y[QUO_W-1:0]);
    end
    if (cmd.off_mul) begin
      inb_r      <= inb_x && inb_y;
      row_prod_r <= py_u * stride_r;
      col_prod_r <= px_u * pbits_r[PBITS_W-1:3];
    end
    if (cmd.out_load) begin
      out_data_r.pixel_offset    <= inb_r ? off_sum[OFF_W-1:0] : '0;
      out_data_r.pixel_color     <= color_r;
      out_data_r.pixel_in_bounds <= inb_r;
      out_data_r.line_done       <= (index_nxt == total_r);
    end
  end

  // Lane y only runs alongside lane x with the same count, so either flag
  // marks completion.
  assign stat.iter_done  = done_x || done_y;
  assign stat.step_avail = (index_r < total_r);
  assign out_data        = out_data_r;

endmodule
